>>> rtl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_IMPLIES(name, clk, rstn, ante, cons)
`define ASSERT_NEVER(name, clk, rstn, cond)
`endif
`endif

>>> rtl/tmcv_pkg.sv
// shared types and constants for the text mode character video block
`timescale 1ns / 1ps
package tmcv_pkg;

  localparam int TEXT_COLUMNS_DEF = 32;
  localparam int TEXT_ROWS_DEF    = 24;
  localparam int GLYPH_BYTES      = 1024;
  localparam int GLYPH_AW         = 10;
  localparam int STORE_AW         = 10;
  localparam int CFG_IW           = 1;
  localparam int COLOR_W          = 32;

  localparam logic [COLOR_W-1:0] INK_RESET   = 32'hffff_ffff;
  localparam logic [COLOR_W-1:0] PAPER_RESET = 32'hff00_0000;

  typedef enum logic [1:0] {
    KIND_SCREEN_WR = 2'd0,
    KIND_GLYPH_WR  = 2'd1,
    KIND_PIXEL     = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_SCREEN_WR = 2'd0,
    OP_GLYPH_WR  = 2'd1,
    OP_PIXEL     = 2'd2
  } op_e;

  typedef enum logic [CFG_IW-1:0] {
    CFG_INK   = 1'b0,
    CFG_PAPER = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    op_e                 op;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          data;
  } entry_t;

endpackage

>>> rtl/tmcv_if.sv
// valid/ready channel interfaces for input words and pixel words
`timescale 1ns / 1ps
interface tmcv_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [9:0] store_address;
  logic [7:0] store_data;

  modport source (output valid, kind, store_address, store_data, input ready);
  modport sink (input valid, kind, store_address, store_data, output ready);
endinterface

interface tmcv_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_color;
  logic [7:0]  pixel_column;
  logic [7:0]  pixel_line;
  logic        line_end;
  logic        frame_end;

  modport source (output valid, pixel_color, pixel_column, pixel_line, line_end,
                  frame_end, input ready);
  modport sink (input valid, pixel_color, pixel_column, pixel_line, line_end,
                frame_end, output ready);
endinterface

>>> rtl/tmcv_front.sv
// input word decode and two entry queue towards the display pipeline
`timescale 1ns / 1ps
module tmcv_front import tmcv_pkg::*; #(
  parameter int TEXT_COLUMNS = TEXT_COLUMNS_DEF,
  parameter int TEXT_ROWS    = TEXT_ROWS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  tmcv_in_if.sink in_i,
  input  logic   clearing_i,
  output logic   q_valid_o,
  input  logic   q_ready_i,
  output entry_t q_entry_o
);

  localparam int SCREEN_BYTES = TEXT_COLUMNS * TEXT_ROWS;

  entry_t     fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       accept, keep, push, pop;
  entry_t     entry;

  always_comb begin
    entry.addr = in_i.store_address;
    entry.data = in_i.store_data;
    entry.op   = OP_PIXEL;
    keep       = 1'b0;
    case (in_i.kind)
      KIND_SCREEN_WR: begin
        entry.op = OP_SCREEN_WR;
        keep     = {2'b00, in_i.store_address} < 12'(SCREEN_BYTES);
      end
      KIND_GLYPH_WR: begin
        entry.op = OP_GLYPH_WR;
        keep     = 1'b1;
      end
      KIND_PIXEL: begin
        entry.op = OP_PIXEL;
        keep     = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_i.ready = !clearing_i && (count_q != 2'd2);
  assign accept     = in_i.valid && in_i.ready;
  assign push       = accept && keep;
  assign q_valid_o  = (count_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_entry_o  = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    case ({push, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= entry;
    end
  end

endmodule

>>> rtl/tmcv_back.sv
// screen and glyph stores, raster counters and pixel pipeline
`timescale 1ns / 1ps
module tmcv_back import tmcv_pkg::*; #(
  parameter int TEXT_COLUMNS = TEXT_COLUMNS_DEF,
  parameter int TEXT_ROWS    = TEXT_ROWS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  entry_t             q_entry_i,
  input  logic [COLOR_W-1:0] ink_i,
  input  logic [COLOR_W-1:0] paper_i,
  output logic               clearing_o,
  tmcv_out_if.source         out_o
);

  localparam int SCREEN_BYTES = TEXT_COLUMNS * TEXT_ROWS;
  localparam int PIXEL_WIDTH  = TEXT_COLUMNS * 8;
  localparam int PIXEL_HEIGHT = TEXT_ROWS * 8;
  localparam int CW           = $clog2(PIXEL_WIDTH);
  localparam int LW           = $clog2(PIXEL_HEIGHT);
  localparam int SAW          = (SCREEN_BYTES > 1) ? $clog2(SCREEN_BYTES) : 1;
  localparam int CLR_LEN      = (SCREEN_BYTES > GLYPH_BYTES) ? SCREEN_BYTES : GLYPH_BYTES;
  localparam int CLW          = $clog2(CLR_LEN);

  logic [7:0] scr_mem [SCREEN_BYTES];
  logic [7:0] gly_mem [GLYPH_BYTES];

  logic           clr_q;
  logic [CLW-1:0] clr_addr_q;
  logic [CW-1:0]  col_q, col_d;
  logic [LW-1:0]  line_q, line_d;

  logic adv, pop, pix, last_col, last_line;
  logic [SAW-1:0] cell_idx, scr_wa;
  logic [GLYPH_AW-1:0] gly_wa, gly_ra;
  logic [7:0] scr_wd, gly_wd, glyph_row;
  logic scr_we, gly_we, ink_bit;

  logic [7:0]    scr_rd_q, gly_rd_q;
  logic          s1_v_q, s2_v_q, out_v_q;
  logic [CW-1:0] s1_col_q, s2_col_q;
  logic [LW-1:0] s1_line_q, s2_line_q;
  logic          s1_lc_q, s1_lf_q, s2_lc_q, s2_lf_q, s2_inv_q;
  logic [COLOR_W-1:0] out_color_q;
  logic [7:0]    out_col_q, out_line_q;
  logic          out_lc_q, out_lf_q;

  assign clearing_o = clr_q;
  assign adv        = !out_v_q || out_o.ready;
  assign q_ready_o  = !clr_q && adv;
  assign pop        = q_valid_i && q_ready_o;
  assign pix        = pop && (q_entry_i.op == OP_PIXEL);
  assign last_col   = (col_q == CW'(PIXEL_WIDTH - 1));
  assign last_line  = (line_q == LW'(PIXEL_HEIGHT - 1));
  assign cell_idx   = SAW'(int'(line_q >> 3) * TEXT_COLUMNS + int'(col_q >> 3));
  assign gly_ra     = {scr_rd_q[6:0], s1_line_q[2:0]};
  assign glyph_row  = gly_rd_q ^ {8{s2_inv_q}};
  assign ink_bit    = glyph_row[~s2_col_q[2:0]];

  // store write port, the clearing sweep owns it after reset
  always_comb begin
    if (clr_q) begin
      scr_we = {1'b0, clr_addr_q} < (CLW + 1)'(SCREEN_BYTES);
      scr_wa = SAW'(clr_addr_q);
      scr_wd = 8'hff;
      gly_we = {1'b0, clr_addr_q} < (CLW + 1)'(GLYPH_BYTES);
      gly_wa = GLYPH_AW'(clr_addr_q);
      gly_wd = 8'hff;
    end else begin
      scr_we = pop && (q_entry_i.op == OP_SCREEN_WR);
      scr_wa = SAW'(q_entry_i.addr);
      scr_wd = q_entry_i.data;
      gly_we = pop && (q_entry_i.op == OP_GLYPH_WR);
      gly_wa = GLYPH_AW'(q_entry_i.addr);
      gly_wd = q_entry_i.data;
    end
  end

  always_comb begin
    col_d  = col_q;
    line_d = line_q;
    if (pix) begin
      if (last_col) begin
        col_d  = '0;
        line_d = last_line ? '0 : line_q + LW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      col_q      <= '0;
      line_q     <= '0;
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      if (clr_q) begin
        if (clr_addr_q == CLW'(CLR_LEN - 1)) begin
          clr_q <= 1'b0;
        end else begin
          clr_addr_q <= clr_addr_q + CLW'(1);
        end
      end
      col_q  <= col_d;
      line_q <= line_d;
      if (adv) begin
        s1_v_q  <= pix;
        s2_v_q  <= s1_v_q;
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scr_we) begin
      scr_mem[scr_wa] <= scr_wd;
    end
    if (adv) begin
      scr_rd_q <= scr_mem[cell_idx];
    end
  end

  // read before write, so a later glyph write cannot overtake this pixel
  always_ff @(posedge clk_i) begin
    if (gly_we) begin
      gly_mem[gly_wa] <= gly_wd;
    end
    if (adv) begin
      gly_rd_q <= gly_mem[gly_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_col_q    <= col_q;
      s1_line_q   <= line_q;
      s1_lc_q     <= last_col;
      s1_lf_q     <= last_col && last_line;
      s2_col_q    <= s1_col_q;
      s2_line_q   <= s1_line_q;
      s2_lc_q     <= s1_lc_q;
      s2_lf_q     <= s1_lf_q;
      s2_inv_q    <= scr_rd_q[7];
      out_color_q <= ink_bit ? ink_i : paper_i;
      out_col_q   <= 8'(s2_col_q);
      out_line_q  <= 8'(s2_line_q);
      out_lc_q    <= s2_lc_q;
      out_lf_q    <= s2_lf_q;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.pixel_color  = out_color_q;
  assign out_o.pixel_column = out_col_q;
  assign out_o.pixel_line   = out_line_q;
  assign out_o.line_end     = out_lc_q;
  assign out_o.frame_end    = out_lf_q;

endmodule

>>> rtl/text_mode_character_video_top.sv
// top level of the text mode character video block
// path: a pixel tick word passes the two entry queue, then the s1, s2 and output registers
// throughput: one input word per cycle bar stalls, set by the single store write and read ports
// reset: counters cleared, then a sweep over max(columns*rows, 1024) addresses fills
// both stores with 0xff; no input word is taken until it ends, colour writes always are
`timescale 1ns / 1ps
`include "assert_macros.svh"
module text_mode_character_video_top import tmcv_pkg::*; #(
  parameter int TEXT_COLUMNS = TEXT_COLUMNS_DEF,
  parameter int TEXT_ROWS    = TEXT_ROWS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  tmcv_in_if.sink            in_i,
  tmcv_out_if.source         out_o,
  input  logic               cfg_we_i,
  input  logic [CFG_IW-1:0]  cfg_index_i,
  input  logic [COLOR_W-1:0] cfg_data_i
);

  localparam int PIXEL_WIDTH = TEXT_COLUMNS * 8;

  logic [COLOR_W-1:0] ink_q, paper_q;
  logic               clearing;
  logic               q_valid, q_ready;
  entry_t             q_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ink_q   <= INK_RESET;
      paper_q <= PAPER_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_INK:   ink_q <= cfg_data_i;
        CFG_PAPER: paper_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  tmcv_front #(
    .TEXT_COLUMNS(TEXT_COLUMNS),
    .TEXT_ROWS   (TEXT_ROWS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .clearing_i (clearing),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_entry_o  (q_entry)
  );

  tmcv_back #(
    .TEXT_COLUMNS(TEXT_COLUMNS),
    .TEXT_ROWS   (TEXT_ROWS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_ready_o  (q_ready),
    .q_entry_i  (q_entry),
    .ink_i      (ink_q),
    .paper_i    (paper_q),
    .clearing_o (clearing),
    .out_o      (out_o)
  );

  `ASSERT_NEVER(no_word_while_clearing, clk_i, rst_ni, clearing && in_i.ready)
  `ASSERT_IMPLIES(frame_end_on_line_end, clk_i, rst_ni, out_o.valid && out_o.frame_end, out_o.line_end)
  `ASSERT_IMPLIES(line_end_on_last_column, clk_i, rst_ni, out_o.valid && out_o.line_end, out_o.pixel_column == 8'(PIXEL_WIDTH - 1))

endmodule

>>> bench/tmcv_checker.sv
// checker: predicts each pixel word of the text display and compares it with the output
`timescale 1ns / 1ps
module tmcv_checker import tmcv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  tmcv_in_if                 in_mon,
  tmcv_out_if                out_mon,
  input  logic               cfg_we_i,
  input  logic [CFG_IW-1:0]  cfg_index_i,
  input  logic [COLOR_W-1:0] cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int SCREEN_BYTES = TEXT_COLUMNS_DEF * TEXT_ROWS_DEF;
  localparam int PIXEL_WIDTH  = TEXT_COLUMNS_DEF * 8;
  localparam int PIXEL_HEIGHT = TEXT_ROWS_DEF * 8;
  localparam int REPORT_LIMIT = 40;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [7:0]         column;
    logic [7:0]         line;
    logic               line_end;
    logic               frame_end;
  } pixel_t;

  logic [7:0]         screen_mem [SCREEN_BYTES];
  logic [7:0]         glyph_mem [GLYPH_BYTES];
  int                 col_pos;
  int                 line_pos;
  logic [COLOR_W-1:0] ink;
  logic [COLOR_W-1:0] paper;
  pixel_t             pixel_q [$];
  int                 fails = 0;
  int                 pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  // raster position advances after every pixel
  function automatic pixel_t render_pixel();
    logic [7:0] cell_byte;
    logic [7:0] row_bits;
    int         cell_idx;
    pixel_t     px;
    cell_idx  = (line_pos >> 3) * TEXT_COLUMNS_DEF + (col_pos >> 3);
    cell_byte = screen_mem[cell_idx % SCREEN_BYTES];
    row_bits  = glyph_mem[{cell_byte[6:0], line_pos[2:0]}];
    if (cell_byte[7]) begin
      row_bits = ~row_bits;
    end
    px.color     = row_bits[7 - col_pos[2:0]] ? ink : paper;
    px.column    = col_pos[7:0];
    px.line      = line_pos[7:0];
    px.line_end  = (col_pos + 1 >= PIXEL_WIDTH);
    px.frame_end = px.line_end && (line_pos + 1 >= PIXEL_HEIGHT);
    if (px.line_end) begin
      col_pos  = 0;
      line_pos = px.frame_end ? 0 : line_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return px;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      fails++;
      if (fails <= REPORT_LIMIT) begin
        $display("%0t: pixel %s mismatch, expected %h, got %h", $time, field, want, got);
      end
    end
  endtask

  always @(posedge clk_i) begin
    pixel_t want;
    if (!rst_ni) begin
      foreach (screen_mem[i]) screen_mem[i] = 8'hff;
      foreach (glyph_mem[i]) glyph_mem[i] = 8'hff;
      col_pos  = 0;
      line_pos = 0;
      ink      = INK_RESET;
      paper    = PAPER_RESET;
      pixel_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_INK:   ink = cfg_data_i;
          CFG_PAPER: paper = cfg_data_i;
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pixel_q.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT) begin
            $display("%0t: unexpected pixel word, expected none, got %h at %0d,%0d", $time,
                     out_mon.pixel_color, out_mon.pixel_column, out_mon.pixel_line);
          end
        end else begin
          want = pixel_q.pop_front();
          check_field("colour", want.color, out_mon.pixel_color);
          check_field("column", want.column, out_mon.pixel_column);
          check_field("line", want.line, out_mon.pixel_line);
          check_field("line_end", want.line_end, out_mon.line_end);
          check_field("frame_end", want.frame_end, out_mon.frame_end);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.kind)
          KIND_SCREEN_WR: begin
            if (in_mon.store_address < SCREEN_BYTES) begin
              screen_mem[in_mon.store_address] = in_mon.store_data;
            end
          end
          KIND_GLYPH_WR: glyph_mem[in_mon.store_address] = in_mon.store_data;
          KIND_PIXEL:    pixel_q.push_back(render_pixel());
          default: ;
        endcase
      end
    end
    pending = pixel_q.size();
  end

endmodule

>>> bench/testbench.sv
// testbench top: drives store writes and pixel ticks into the text display and gives the verdict
`timescale 1ns / 1ps
module testbench;
  import tmcv_pkg::*;

  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam int         IDLE_LIMIT   = 5000;
  localparam int         SETTLE       = 10;
  localparam int         BATCH_WORDS  = 400;
  localparam int         BURST_WORDS  = 100;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [CFG_IW-1:0]  cfg_index;
  logic [COLOR_W-1:0] cfg_data;
  bit                 tx_quiet;
  bit                 rx_quiet;
  int                 fail_count;
  int                 pending;
  int                 idle_cycles;

  tmcv_in_if  pix_in ();
  tmcv_out_if pix_out ();

  text_mode_character_video_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (pix_in),
    .out_o       (pix_out),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  tmcv_checker pixel_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (pix_in),
    .out_mon      (pix_out),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // pixel word receiver with random stalls
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = rx_quiet ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        pix_out.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pix_out.ready = 1'b1;
      do @(posedge clk_i); while (!(pix_out.valid && pix_out.ready));
      @(negedge clk_i);
    end
  end

  task automatic send_word(input logic [1:0] kind, input logic [9:0] addr,
                           input logic [7:0] data);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      pix_in.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix_in.kind          = kind;
    pix_in.store_address = addr;
    pix_in.store_data    = data;
    pix_in.valid         = 1'b1;
    do @(posedge clk_i); while (!(pix_in.valid && pix_in.ready));
    @(negedge clk_i);
  endtask

  task automatic write_colour(input cfg_reg_e idx, input logic [COLOR_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // hold off until every pixel word is back and the pipe is empty
  task automatic settle();
    pix_in.valid = 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic random_words(input int count);
    int         pick;
    logic [9:0] addr;
    for (int i = 0; i < count; i++) begin
      if (i % 32 == 0) begin
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      addr = ($urandom_range(0, 9) < 6) ? 10'($urandom_range(0, 127)) : 10'($urandom_range(0, 1023));
      if (pick < 55) begin
        send_word(KIND_PIXEL, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
      end else if (pick < 75) begin
        send_word(KIND_SCREEN_WR, addr, 8'($urandom_range(0, 255)));
      end else if (pick < 95) begin
        send_word(KIND_GLYPH_WR, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
      end else begin
        send_word(KIND_UNUSED, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = CFG_INK;
    cfg_data             = '0;
    pix_in.valid         = 1'b0;
    pix_in.kind          = KIND_SCREEN_WR;
    pix_in.store_address = '0;
    pix_in.store_data    = '0;
    pix_out.ready        = 1'b0;
    tx_quiet             = 1'b0;
    rx_quiet             = 1'b0;
    idle_cycles          = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    write_colour(CFG_INK, 32'h0000_0000);
    write_colour(CFG_PAPER, 32'hffff_ffff);

    // reset fill, store ends, ignored addresses, unused kind, inverted cell
    send_word(KIND_PIXEL, 10'd0, 8'd0);
    send_word(KIND_SCREEN_WR, 10'd0, 8'h00);
    send_word(KIND_GLYPH_WR, 10'd0, 8'ha5);
    send_word(KIND_GLYPH_WR, 10'd1023, 8'h00);
    send_word(KIND_SCREEN_WR, 10'd767, 8'h7f);
    send_word(KIND_SCREEN_WR, 10'd768, 8'h00);
    send_word(KIND_SCREEN_WR, 10'd1023, 8'h00);
    send_word(KIND_UNUSED, 10'd1023, 8'hff);
    send_word(KIND_SCREEN_WR, 10'd1, 8'h80);
    repeat (15) send_word(KIND_PIXEL, 10'd0, 8'd0);
    settle();

    write_colour(CFG_INK, $urandom());
    write_colour(CFG_PAPER, $urandom());
    random_words(BATCH_WORDS);
    settle();

    write_colour(CFG_INK, 32'hffff_ffff);
    write_colour(CFG_PAPER, 32'h0000_0000);
    random_words(BATCH_WORDS);
    settle();

    // a burst of pixel ticks back to back
    write_colour(CFG_INK, $urandom());
    write_colour(CFG_PAPER, $urandom());
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    repeat (BURST_WORDS) send_word(KIND_PIXEL, 10'($urandom_range(0, 1023)), 8'($urandom()));
    settle();

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
